/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that a trigger implies a consequence at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/cyr2lat_pkg.sv */
// ----------------------------------------------------------------------------
// cyr2lat_pkg
// Types, code points and the letter table of the Cyrillic to Latin block.
// ----------------------------------------------------------------------------
package cyr2lat_pkg;

  localparam logic [7:0]  TopBit     = 8'h80;
  localparam logic [7:0]  LeadD0     = 8'hD0;
  localparam logic [7:0]  LeadD1     = 8'hD1;
  localparam logic [7:0]  D0First    = 8'h90;
  localparam logic [7:0]  D0Last     = 8'hBF;
  localparam logic [7:0]  D1First    = 8'h80;
  localparam logic [7:0]  D1Last     = 8'h8F;
  localparam logic [15:0] CodeYoUp   = 16'hD081;
  localparam logic [15:0] CodeYoLow  = 16'hD191;
  localparam logic [15:0] CodeDash   = 16'hE280;
  localparam logic [7:0]  ChrSpace   = 8'h20;
  localparam logic [7:0]  ChrApos    = 8'h27;
  localparam logic [7:0]  ChrDash    = 8'h2D;
  localparam logic [7:0]  CaseBit    = 8'h20;

  // One or two Latin bytes for a code
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       two;
  } lat_pair_t;

  // Results and next held state for one item
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       hold_vld;
    logic [7:0] hold_byte;
  } step_res_t;

  function automatic lat_pair_t mk1(logic [7:0] a);
    lat_pair_t p;
    p.first  = a;
    p.second = 8'h00;
    p.two    = 1'b0;
    return p;
  endfunction

  function automatic lat_pair_t mk2(logic [7:0] a, logic [7:0] b);
    lat_pair_t p;
    p.first  = a;
    p.second = b;
    p.two    = 1'b1;
    return p;
  endfunction

  // Letter table: upper half of idx selects lower case
  function automatic lat_pair_t letter(logic [5:0] idx);
    lat_pair_t p;
    case (idx[4:0])
      5'd0:  p = mk1("A");
      5'd1:  p = mk1("B");
      5'd2:  p = mk1("V");
      5'd3:  p = mk1("G");
      5'd4:  p = mk1("D");
      5'd5:  p = mk1("E");
      5'd6:  p = mk2("Z", "h");
      5'd7:  p = mk1("Z");
      5'd8:  p = mk1("I");
      5'd9:  p = mk1("Y");
      5'd10: p = mk1("K");
      5'd11: p = mk1("L");
      5'd12: p = mk1("M");
      5'd13: p = mk1("N");
      5'd14: p = mk1("O");
      5'd15: p = mk1("P");
      5'd16: p = mk1("R");
      5'd17: p = mk1("S");
      5'd18: p = mk1("T");
      5'd19: p = mk1("U");
      5'd20: p = mk1("F");
      5'd21: p = mk1("H");
      5'd22: p = mk2("T", "s");
      5'd23: p = mk2("C", "h");
      5'd24: p = mk2("S", "h");
      5'd25: p = mk2("S", "h");
      5'd26: p = mk1(ChrApos);
      5'd27: p = mk1("Y");
      5'd28: p = mk1(ChrApos);
      5'd29: p = mk1("E");
      5'd30: p = mk2("Y", "u");
      default: p = mk2("Y", "a");
    endcase
    // Fold letters to lower case, leave the soft and hard signs alone
    if (idx[5] && (p.first != ChrApos)) begin
      p.first = p.first | CaseBit;
    end
    return p;
  endfunction

  // Map a two-byte code to Latin bytes, unknown codes to a space
  function automatic lat_pair_t lookup(logic [7:0] hi, logic [7:0] lo);
    lat_pair_t  p;
    logic [7:0] off;
    off = lo - D0First;
    if ((hi == LeadD0) && (lo >= D0First) && (lo <= D0Last)) begin
      p = letter(off[5:0]);
    end else if ((hi == LeadD1) && (lo >= D1First) && (lo <= D1Last)) begin
      p = letter({2'b11, lo[3:0]});
    end else if ({hi, lo} == CodeYoUp) begin
      p = mk2("Y", "o");
    end else if ({hi, lo} == CodeYoLow) begin
      p = mk2("y", "o");
    end else if ({hi, lo} == CodeDash) begin
      p = mk1(ChrDash);
    end else begin
      p = mk1(ChrSpace);
    end
    return p;
  endfunction

endpackage

/* hw/rtl/cyr2lat_if.sv */
// ----------------------------------------------------------------------------
// cyr2lat interfaces
// Valid/ready channels for text bytes in and Latin bytes out.
// ----------------------------------------------------------------------------
interface cyr2lat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface cyr2lat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* hw/rtl/utf8_cyrillic_to_latin_transliterator.sv */
// ----------------------------------------------------------------------------
// utf8_cyrillic_to_latin_transliterator
// UTF-8 Cyrillic text in, Latin transliteration out, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one text byte per item with end_of_text on the final byte.
//   out_o carries result bytes; last_of_run marks the last result of an item.
//   A top-bit byte arriving with no byte held and without end_of_text is held
//   until the next item: an item may produce zero, one or two results.
// Path: an accepted item is registered in the input register, translated there
//   once the result register can take it, and its first result is offered
//   from the result register.
// Throughput: one item per cycle while out_o.ready is high and each gives at
//   most one result; after an item with two results the next item waits in
//   the input register until the single output port has taken the second
//   result from the two-entry result register.
// Reset: clears the input valid flag, the result count and the held byte;
//   nothing is offered until the first item arrives.
// Stall: while out_o.ready is low the current result holds; one item waits
//   in the input register and in_i.ready drops until results drain.
// ----------------------------------------------------------------------------
module utf8_cyrillic_to_latin_transliterator (
  input  logic          clk_i,
  input  logic          rst_ni,
  cyr2lat_in_if.sink    in_i,
  cyr2lat_out_if.source out_o
);
  import cyr2lat_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_end_q, in_end_d;
  logic       held_vld_q, held_vld_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] b0_q, b0_d;
  logic [7:0] b1_q, b1_d;
  logic       last0_q, last0_d;
  logic       out_fire, load_ok, consume, in_fire;
  step_res_t  res;

  cyr2lat_step u_step (
    .held_vld_i  (held_vld_q),
    .held_byte_i (held_byte_q),
    .byte_i      (in_byte_q),
    .end_i       (in_end_q),
    .res_o       (res)
  );

  // Handshake
  assign out_fire    = out_o.valid && out_o.ready;
  assign load_ok     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire);
  assign consume     = in_vld_q && load_ok;
  assign in_i.ready  = !in_vld_q || load_ok;
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.out_byte    = b0_q;
  assign out_o.last_of_run = last0_q;

  // Load the input register, drop it once translated
  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    in_end_d  = in_end_q;
    if (in_fire) begin
      in_vld_d  = 1'b1;
      in_byte_d = in_i.in_byte;
      in_end_d  = in_i.end_of_text;
    end else if (consume) begin
      in_vld_d  = 1'b0;
    end
  end

  // Advance the held byte and the result register
  always_comb begin
    held_vld_d  = held_vld_q;
    held_byte_d = held_byte_q;
    cnt_d       = cnt_q;
    b0_d        = b0_q;
    b1_d        = b1_q;
    last0_d     = last0_q;
    if (consume) begin
      held_vld_d  = res.hold_vld;
      held_byte_d = res.hold_byte;
      cnt_d       = res.cnt;
      b0_d        = res.b0;
      b1_d        = res.b1;
      last0_d     = (res.cnt == 2'd1);
    end else if (out_fire) begin
      cnt_d       = cnt_q - 2'd1;
      b0_d        = b1_q;
      last0_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      held_vld_q  <= 1'b0;
      held_byte_q <= 8'h00;
      cnt_q       <= 2'd0;
      last0_q     <= 1'b0;
    end else begin
      in_vld_q    <= in_vld_d;
      held_vld_q  <= held_vld_d;
      held_byte_q <= held_byte_d;
      cnt_q       <= cnt_d;
      last0_q     <= last0_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_end_q  <= in_end_d;
    b0_q      <= b0_d;
    b1_q      <= b1_d;
  end

endmodule

/* hw/rtl/cyr2lat_step.sv */
// ----------------------------------------------------------------------------
// cyr2lat_step
// Combinational translation of one byte against the held lead byte.
// ----------------------------------------------------------------------------
module cyr2lat_step (
  input  logic                   held_vld_i,
  input  logic [7:0]             held_byte_i,
  input  logic [7:0]             byte_i,
  input  logic                   end_i,
  output cyr2lat_pkg::step_res_t res_o
);
  import cyr2lat_pkg::*;

  lat_pair_t pair;

  assign pair = lookup(held_byte_i, byte_i);

  // Pick results and next held state
  always_comb begin
    res_o           = '0;
    res_o.b0        = byte_i;
    if (held_vld_i) begin
      if ((byte_i & TopBit) != 8'h00) begin
        res_o.b0  = pair.first;
        res_o.b1  = pair.second;
        res_o.cnt = pair.two ? 2'd2 : 2'd1;
      end else begin
        res_o.b0  = held_byte_i;
        res_o.b1  = byte_i;
        res_o.cnt = 2'd2;
      end
    end else if (((byte_i & TopBit) != 8'h00) && !end_i) begin
      res_o.hold_vld  = 1'b1;
      res_o.hold_byte = byte_i;
    end else begin
      res_o.cnt = 2'd1;
    end
  end

endmodule

/* hw/rtl/cyr2lat_checker.sv */
// ----------------------------------------------------------------------------
// cyr2lat_checker
// Port-level assertions for the transliterator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cyr2lat_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
               out_valid_i && $stable(out_byte_i) && $stable(out_last_i))

  // The second byte of a two-byte run follows at once
  `ASSERT_NEXT(a_run_cont, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i,
               out_valid_i)

  // With no result pending, the block takes an item
  `ASSERT_ALWAYS(a_idle_ready, clk_i, rst_ni, !out_valid_i |-> in_ready_i)

endmodule

bind utf8_cyrillic_to_latin_transliterator cyr2lat_checker u_cyr2lat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last_of_run)
);
